FILE: sv/rskdm_pkg.sv
package rskdm_pkg;

   localparam int unsigned NUM_KEY_REGS = 8;

   typedef enum logic [2:0] {
      REG_FOCUS    = 3'd0,
      REG_PHOTO    = 3'd1,
      REG_BRIGHTER = 3'd2,
      REG_TURN_POS = 3'd3,
      REG_DIMMER   = 3'd4,
      REG_TURN_NEG = 3'd5,
      REG_BACK     = 3'd6,
      REG_ARM_ONE  = 3'd7
   } csr_reg_type;

   typedef logic [11:0] level_type;

   localparam level_type KEY_LEVEL_RESET [NUM_KEY_REGS] = '{
      12'd3383, 12'd2695, 12'd1999, 12'd1617, 12'd490, 12'd1261, 12'd2347, 12'd1801
   };

   // ladder decoding
   localparam logic signed [12:0] KEY_WINDOW = 13'sd50;

   // stick conditioning
   localparam int unsigned       STICK_SHIFT = 5;
   localparam logic        [7:0] STICK_HIGH  = 8'd77;
   localparam logic        [7:0] STICK_LOW   = 8'd50;

   // drive mixer
   localparam logic signed [6:0] DEAD_ZONE   = 7'sd20;
   localparam logic signed [9:0] DRIVE_GAIN  = 10'sd5;
   localparam logic signed [9:0] DRIVE_START = 10'sd6;

   // brightness and rotate
   localparam logic        [8:0] LIGHT_STEP  = 9'd64;
   localparam logic        [8:0] LIGHT_MAX   = 9'd255;
   localparam logic signed [6:0] ROTATE_MAG  = 7'sd50;

   typedef struct packed {
      logic focus;
      logic photo;
      logic brighter;
      logic turn_pos;
      logic dimmer;
      logic turn_neg;
      logic back;
      logic arm_one;
      logic arm_two;
   } key_hits_type;

endpackage

FILE: sv/rskdm_key_decode.sv
module rskdm_key_decode
   import rskdm_pkg::*;
#(
   parameter int unsigned KEY_LEVEL_ARM_TWO = 1482
) (
   input  level_type    sample,
   input  level_type    levels [NUM_KEY_REGS],
   output key_hits_type hits
);

   localparam level_type ArmTwoLevel = level_type'(KEY_LEVEL_ARM_TWO);

   // strict window of +-KEY_WINDOW around the key level
   function automatic logic hit(input level_type smp, input level_type lvl);
      logic signed [12:0] diff;
      diff = $signed({1'b0, smp}) - $signed({1'b0, lvl});
      return (diff > -KEY_WINDOW) && (diff < KEY_WINDOW);
   endfunction

   always_comb begin
      hits.focus    = hit(sample, levels[REG_FOCUS]);
      hits.photo    = hit(sample, levels[REG_PHOTO]);
      hits.brighter = hit(sample, levels[REG_BRIGHTER]);
      hits.turn_pos = hit(sample, levels[REG_TURN_POS]);
      hits.dimmer   = hit(sample, levels[REG_DIMMER]);
      hits.turn_neg = hit(sample, levels[REG_TURN_NEG]);
      hits.back     = hit(sample, levels[REG_BACK]);
      hits.arm_one  = hit(sample, levels[REG_ARM_ONE]);
      hits.arm_two  = hit(sample, ArmTwoLevel);
   end

endmodule

FILE: sv/rskdm_drive.sv
module rskdm_drive
   import rskdm_pkg::*;
(
   input  logic        [11:0] x_raw,
   input  logic        [11:0] y_raw,
   output logic signed [6:0]  x_offset,
   output logic signed [6:0]  y_offset,
   output logic signed [9:0]  speed_left,
   output logic signed [9:0]  speed_right
);

   // divide by 32, then dead band around mid scale
   function automatic logic signed [6:0] stick_offset(input logic [11:0] raw);
      logic [7:0] v;
      v = {1'b0, 7'(raw >> STICK_SHIFT)};
      if (v > STICK_HIGH) begin
         return 7'(v - STICK_HIGH);
      end else if (v < STICK_LOW) begin
         return 7'(v - STICK_LOW);
      end
      return 7'sd0;
   endfunction

   logic               x_mid, y_mid, x_left, x_right, y_fwd, y_back;
   logic signed [9:0]  x_wide, y_wide;
   logic signed [9:0]  x_scaled, y_scaled;

   assign x_offset = stick_offset(x_raw);
   assign y_offset = stick_offset(y_raw);

   assign x_mid   = (x_offset > -DEAD_ZONE) && (x_offset < DEAD_ZONE);
   assign y_mid   = (y_offset > -DEAD_ZONE) && (y_offset < DEAD_ZONE);
   assign x_right = x_offset > DEAD_ZONE;
   assign x_left  = x_offset < -DEAD_ZONE;
   assign y_fwd   = y_offset > DEAD_ZONE;
   assign y_back  = y_offset < -DEAD_ZONE;

   assign x_wide   = 10'(x_offset);
   assign y_wide   = 10'(y_offset);
   assign x_scaled = x_wide * DRIVE_GAIN;
   assign y_scaled = y_wide * DRIVE_GAIN;

   always_comb begin
      speed_left  = 10'sd0;
      speed_right = 10'sd0;
      if (y_fwd && x_mid) begin
         speed_left  = y_scaled + DRIVE_START;
         speed_right = y_scaled + DRIVE_START;
      end else if (y_back && x_mid) begin
         speed_left  = y_scaled - DRIVE_START;
         speed_right = y_scaled - DRIVE_START;
      end else if (x_left && y_mid) begin
         speed_left  = x_scaled - DRIVE_START;
         speed_right = DRIVE_START - x_scaled;
      end else if (x_right && y_mid) begin
         speed_left  = x_scaled + DRIVE_START;
         speed_right = -(x_scaled + DRIVE_START);
      end else if (y_fwd && x_left) begin
         speed_right = y_scaled + DRIVE_START;
      end else if (y_fwd && x_right) begin
         speed_left  = y_scaled + DRIVE_START;
      end else if (y_back && x_left) begin
         speed_right = y_scaled - DRIVE_START;
      end else if (y_back && x_right) begin
         speed_left  = y_scaled - DRIVE_START;
      end
   end

endmodule

FILE: sv/remote_stick_keypad_drive_mixer.sv
// Remote-control front end: stick conditioning, resistor-ladder key decode
// and an eight-direction tank-drive mixer.
//
// req_ channel: one set of raw 12-bit readings (stick X, stick Y, ladder).
// rsp_ channel: one result per request, in order: stick offsets, key flags,
//   brightness and left/right track speeds.
// csr_ port: write-only key ladder levels, register index 0..7, low 12 bits
//   of csr_wdata kept; write only while no request is in flight.
//
// The request lands in an input register on its transfer edge; the compare/mix
// logic between is combinational and feeds the response register, which loads
// as soon as it is free and drives rsp_valid. Throughput is one item per cycle
// while rsp_ready holds.
// When the receiver stalls, the response register holds and the input
// register fills; req_ready drops only once both are full.
// Reset (synchronous) restores the key levels to their defaults, clears the
// key history, sticky flag and brightness, and empties both stages.
module remote_stick_keypad_drive_mixer
   import rskdm_pkg::*;
#(
   parameter int unsigned KEY_LEVEL_ARM_TWO = 1482
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [11:0] req_stick_x_raw,
   input  logic        [11:0] req_stick_y_raw,
   input  logic        [11:0] req_ladder_raw,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [6:0]  rsp_stick_x_offset,
   output logic signed [6:0]  rsp_stick_y_offset,
   output logic               rsp_focus_pulse,
   output logic               rsp_photo_pulse,
   output logic               rsp_set_latched,
   output logic signed [6:0]  rsp_rotate_value,
   output logic               rsp_back_held,
   output logic               rsp_arm_one_held,
   output logic               rsp_arm_two_held,
   output logic        [7:0]  rsp_light_level,
   output logic signed [9:0]  rsp_speed_left,
   output logic signed [9:0]  rsp_speed_right,

   input  logic               csr_wr_en,
   input  csr_reg_type        csr_index,
   input  logic        [11:0] csr_wdata
);

   level_type    key_level_ff [NUM_KEY_REGS];

   logic         in_valid_ff;
   logic  [11:0] in_x_raw_ff, in_y_raw_ff, in_ladder_ff;

   logic         rsp_valid_ff;
   logic         advance;
   logic         out_free;

   logic         focus_seen_ff, photo_seen_ff, set_flag_ff;
   logic  [7:0]  brightness_ff;
   logic  [7:0]  brightness_in;
   logic  [8:0]  bright_up;

   key_hits_type      hits;
   logic signed [6:0] x_offset, y_offset, rotate_in;
   logic signed [9:0] speed_left, speed_right;

   // output register frees up when empty or when its transfer completes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_level_ff <= KEY_LEVEL_RESET;
      end else if (csr_wr_en) begin
         key_level_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_raw_ff  <= req_stick_x_raw;
         in_y_raw_ff  <= req_stick_y_raw;
         in_ladder_ff <= req_ladder_raw;
      end
   end

   rskdm_key_decode #(
      .KEY_LEVEL_ARM_TWO (KEY_LEVEL_ARM_TWO)
   ) u_key_decode (
      .sample (in_ladder_ff),
      .levels (key_level_ff),
      .hits   (hits)
   );

   rskdm_drive u_drive (
      .x_raw       (in_x_raw_ff),
      .y_raw       (in_y_raw_ff),
      .x_offset    (x_offset),
      .y_offset    (y_offset),
      .speed_left  (speed_left),
      .speed_right (speed_right)
   );

   // brightness step: brighter wins over dimmer, saturate at both ends
   assign bright_up = {1'b0, brightness_ff} + LIGHT_STEP;

   always_comb begin
      brightness_in = brightness_ff;
      if (hits.brighter) begin
         brightness_in = (bright_up > LIGHT_MAX) ? LIGHT_MAX[7:0] : bright_up[7:0];
      end else if (hits.dimmer) begin
         brightness_in = ({1'b0, brightness_ff} < LIGHT_STEP) ?
                         8'd0 : 8'({1'b0, brightness_ff} - LIGHT_STEP);
      end
   end

   always_comb begin
      if (hits.turn_pos) begin
         rotate_in = ROTATE_MAG;
      end else if (hits.turn_neg) begin
         rotate_in = -ROTATE_MAG;
      end else begin
         rotate_in = 7'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         focus_seen_ff <= 1'b0;
         photo_seen_ff <= 1'b0;
         set_flag_ff   <= 1'b0;
         brightness_ff <= 8'd0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         // key history moves only when an item is committed to the output
         if (advance) begin
            focus_seen_ff <= hits.focus;
            photo_seen_ff <= hits.photo;
            set_flag_ff   <= set_flag_ff || hits.brighter;
            brightness_ff <= brightness_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_stick_x_offset <= x_offset;
         rsp_stick_y_offset <= y_offset;
         rsp_focus_pulse    <= hits.focus && !focus_seen_ff;
         rsp_photo_pulse    <= hits.photo && !photo_seen_ff;
         rsp_set_latched    <= set_flag_ff || hits.brighter;
         rsp_rotate_value   <= rotate_in;
         rsp_back_held      <= hits.back;
         rsp_arm_one_held   <= hits.arm_one;
         rsp_arm_two_held   <= hits.arm_two;
         rsp_light_level    <= brightness_in;
         rsp_speed_left     <= speed_left;
         rsp_speed_right    <= speed_right;
      end
   end

endmodule

FILE: sv/rskdm_checker.sv
module rskdm_checker
   import rskdm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic        [7:0]  rsp_light_level,
   input logic               rsp_set_latched,
   input logic signed [9:0]  rsp_speed_left,
   input logic signed [9:0]  rsp_speed_right
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its brightness and speeds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_light_level) && $stable(rsp_speed_left)
                                  && $stable(rsp_speed_right))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // once the sticky flag has been transferred, later responses keep it
   a_set_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_set_latched |=> !rsp_valid || rsp_set_latched)
      else $error("sticky set flag cleared");

   // tank mix: one track idle, both equal, or spinning in place
   a_mix_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speed_left == 10'sd0 || rsp_speed_right == 10'sd0
                    || rsp_speed_left == rsp_speed_right
                    || rsp_speed_left == -rsp_speed_right)
      else $error("track speeds outside mixer pattern");

endmodule

bind remote_stick_keypad_drive_mixer rskdm_checker u_rskdm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_light_level (rsp_light_level),
   .rsp_set_latched (rsp_set_latched),
   .rsp_speed_left  (rsp_speed_left),
   .rsp_speed_right (rsp_speed_right)
);

FILE: dv/remote_stick_keypad_drive_mixer_tb.sv
module testbench
   import rskdm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARM_TWO_LEVEL   = 1482;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 6;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int MAX_REPORTS     = 10;

   localparam int STICK_EDGES [9] = '{-50, -21, -20, -19, 0, 19, 20, 21, 50};

   typedef enum int {
      CFG_DEFAULT,
      CFG_RANDOM,
      CFG_LOW,
      CFG_HIGH,
      CFG_CLUSTER
   } level_style_e;

   localparam level_style_e PHASE_STYLE [NUM_PHASES] = '{
      CFG_RANDOM, CFG_LOW, CFG_CLUSTER, CFG_HIGH,
      CFG_RANDOM, CFG_CLUSTER, CFG_DEFAULT, CFG_CLUSTER
   };
   localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 81, 0, 37, 0, 81, 0, 37};
   localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 81, 37, 0, 0, 81, 37};

   typedef struct packed {
      logic signed [6:0] stick_x_offset;
      logic signed [6:0] stick_y_offset;
      logic              focus_pulse;
      logic              photo_pulse;
      logic              set_latched;
      logic signed [6:0] rotate_value;
      logic              back_held;
      logic              arm_one_held;
      logic              arm_two_held;
      logic        [7:0] light_level;
      logic signed [9:0] speed_left;
      logic signed [9:0] speed_right;
   } frame_t;

   // Tracks key history, brightness and ladder levels; holds frames in flight.
   class remote_frame_model;
      level_type key_level [NUM_KEY_REGS];
      int        arm_two_level;
      bit        focus_seen;
      bit        photo_seen;
      bit        set_flag;
      logic [7:0] brightness;
      frame_t    expected_frames [$];
      int        mismatches;
      int        checked;

      function new(int arm_two);
         foreach (key_level[i]) key_level[i] = KEY_LEVEL_RESET[i];
         arm_two_level = arm_two;
         focus_seen = 1'b0;
         photo_seen = 1'b0;
         set_flag = 1'b0;
         brightness = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function int stick_offset(logic [11:0] raw);
         int v;
         v = int'(raw >> STICK_SHIFT);
         if (v > int'(STICK_HIGH)) return v - int'(STICK_HIGH);
         if (v < int'(STICK_LOW)) return v - int'(STICK_LOW);
         return 0;
      endfunction

      function bit near_level(int lvl, int sample);
         return sample < lvl + int'(KEY_WINDOW) && sample > lvl - int'(KEY_WINDOW);
      endfunction

      function void accept_readings(logic [11:0] sx, logic [11:0] sy, logic [11:0] ladder);
         frame_t want;
         int x, y, s, lvl, rot, l, r, dz, g, st;
         bit hit_a, hit_b, hit_c, hit_d, hit_e, hit_f;
         bit x_mid, y_mid, y_fwd, y_back, x_right, x_left;
         x = stick_offset(sx);
         y = stick_offset(sy);
         s = int'(ladder);
         hit_a = near_level(key_level[REG_FOCUS], s);
         hit_b = near_level(key_level[REG_PHOTO], s);
         hit_c = near_level(key_level[REG_BRIGHTER], s);
         hit_d = near_level(key_level[REG_TURN_POS], s);
         hit_e = near_level(key_level[REG_DIMMER], s);
         hit_f = near_level(key_level[REG_TURN_NEG], s);
         want.back_held = near_level(key_level[REG_BACK], s);
         want.arm_one_held = near_level(key_level[REG_ARM_ONE], s);
         want.arm_two_held = near_level(arm_two_level, s);
         want.focus_pulse = hit_a && !focus_seen;
         want.photo_pulse = hit_b && !photo_seen;
         focus_seen = hit_a;
         photo_seen = hit_b;
         rot = hit_d ? int'(ROTATE_MAG) : (hit_f ? -int'(ROTATE_MAG) : 0);

         // brighter wins over dimmer; saturate at both ends
         lvl = int'(brightness);
         if (hit_c) begin
            set_flag = 1'b1;
            lvl += int'(LIGHT_STEP);
            if (lvl > int'(LIGHT_MAX)) lvl = int'(LIGHT_MAX);
         end else if (hit_e) begin
            lvl -= int'(LIGHT_STEP);
            if (lvl < 0) lvl = 0;
         end
         brightness = lvl[7:0];

         dz = int'(DEAD_ZONE);
         g = int'(DRIVE_GAIN);
         st = int'(DRIVE_START);
         x_mid = x > -dz && x < dz;
         y_mid = y > -dz && y < dz;
         y_fwd = y > dz;
         y_back = y < -dz;
         x_right = x > dz;
         x_left = x < -dz;
         l = 0;
         r = 0;
         if (y_fwd && x_mid) begin
            l = y * g + st;
            r = l;
         end else if (y_back && x_mid) begin
            l = y * g - st;
            r = l;
         end else if (x_left && y_mid) begin
            l = x * g - st;
            r = -l;
         end else if (x_right && y_mid) begin
            l = x * g + st;
            r = -l;
         end else if (y_fwd && x_left) begin
            r = y * g + st;
         end else if (y_fwd && x_right) begin
            l = y * g + st;
         end else if (y_back && x_left) begin
            r = y * g - st;
         end else if (y_back && x_right) begin
            l = y * g - st;
         end

         want.stick_x_offset = 7'(x);
         want.stick_y_offset = 7'(y);
         want.set_latched = set_flag;
         want.rotate_value = 7'(rot);
         want.light_level = brightness;
         want.speed_left = 10'(l);
         want.speed_right = 10'(r);
         expected_frames.push_back(want);
      endfunction

      function string frame_text(frame_t f);
         return $sformatf({"x=%0d y=%0d focus=%0b photo=%0b set=%0b rot=%0d back=%0b ",
                           "arm1=%0b arm2=%0b light=%0d left=%0d right=%0d"},
                          f.stick_x_offset, f.stick_y_offset, f.focus_pulse, f.photo_pulse,
                          f.set_latched, f.rotate_value, f.back_held, f.arm_one_held,
                          f.arm_two_held, f.light_level, f.speed_left, f.speed_right);
      endfunction

      function void check_frame(frame_t got);
         frame_t want;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result with nothing outstanding: %s", frame_text(got));
            return;
         end
         want = expected_frames.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("frame %0d mismatch", checked);
               $display("  expected %s", frame_text(want));
               $display("  actual   %s", frame_text(got));
            end
         end
         checked++;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic       [11:0] req_stick_x_raw;
   logic       [11:0] req_stick_y_raw;
   logic       [11:0] req_ladder_raw;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [6:0] rsp_stick_x_offset;
   logic signed [6:0] rsp_stick_y_offset;
   logic              rsp_focus_pulse;
   logic              rsp_photo_pulse;
   logic              rsp_set_latched;
   logic signed [6:0] rsp_rotate_value;
   logic              rsp_back_held;
   logic              rsp_arm_one_held;
   logic              rsp_arm_two_held;
   logic        [7:0] rsp_light_level;
   logic signed [9:0] rsp_speed_left;
   logic signed [9:0] rsp_speed_right;
   logic              csr_wr_en;
   csr_reg_type       csr_index;
   logic       [11:0] csr_wdata;

   remote_frame_model model;
   frame_t            seen_frame;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                hold_off_pending = 1'b0;
   int                quiet_cycles = 0;

   remote_stick_keypad_drive_mixer #(
      .KEY_LEVEL_ARM_TWO(ARM_TWO_LEVEL)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stick_x_raw    (req_stick_x_raw),
      .req_stick_y_raw    (req_stick_y_raw),
      .req_ladder_raw     (req_ladder_raw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_stick_x_offset (rsp_stick_x_offset),
      .rsp_stick_y_offset (rsp_stick_y_offset),
      .rsp_focus_pulse    (rsp_focus_pulse),
      .rsp_photo_pulse    (rsp_photo_pulse),
      .rsp_set_latched    (rsp_set_latched),
      .rsp_rotate_value   (rsp_rotate_value),
      .rsp_back_held      (rsp_back_held),
      .rsp_arm_one_held   (rsp_arm_one_held),
      .rsp_arm_two_held   (rsp_arm_two_held),
      .rsp_light_level    (rsp_light_level),
      .rsp_speed_left     (rsp_speed_left),
      .rsp_speed_right    (rsp_speed_right),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   assign seen_frame = {rsp_stick_x_offset, rsp_stick_y_offset, rsp_focus_pulse,
                        rsp_photo_pulse, rsp_set_latched, rsp_rotate_value, rsp_back_held,
                        rsp_arm_one_held, rsp_arm_two_held, rsp_light_level,
                        rsp_speed_left, rsp_speed_right};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            model.accept_readings(req_stick_x_raw, req_stick_y_raw, req_ladder_raw);
         if (rsp_valid && rsp_ready)
            model.check_frame(seen_frame);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [11:0] raw_for_offset(int off);
      int v;
      if (off > 0) v = off + int'(STICK_HIGH);
      else if (off < 0) v = off + int'(STICK_LOW);
      else v = $urandom_range(int'(STICK_HIGH), int'(STICK_LOW));
      return 12'(v * 32 + int'($urandom_range(31)));
   endfunction

   function automatic logic [11:0] pick_stick_raw();
      case ($urandom_range(2))
         0: return 12'($urandom_range(4095));
         1: return raw_for_offset(int'($urandom_range(100)) - 50);
         default: return raw_for_offset(STICK_EDGES[$urandom_range(8)]);
      endcase
   endfunction

   // Mostly land near a key level, straddling the window edges.
   function automatic logic [11:0] pick_ladder();
      int idx;
      int lvl;
      if ($urandom_range(9) < 3) return 12'($urandom_range(4095));
      idx = $urandom_range(NUM_KEY_REGS);
      lvl = (idx == NUM_KEY_REGS) ? ARM_TWO_LEVEL : int'(model.key_level[idx]);
      lvl += int'($urandom_range(110)) - 55;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      return 12'(lvl);
   endfunction

   task automatic send_readings(logic [11:0] sx, logic [11:0] sy, logic [11:0] ladder);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_stick_x_raw <= sx;
      req_stick_y_raw <= sy;
      req_ladder_raw <= ladder;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_offsets(int xo, int yo, logic [11:0] ladder);
      send_readings(raw_for_offset(xo), raw_for_offset(yo), ladder);
   endtask

   task automatic run_directed();
      level_type lv_a;
      level_type lv_b;
      level_type lv_c;
      level_type lv_e;
      lv_a = KEY_LEVEL_RESET[REG_FOCUS];
      lv_b = KEY_LEVEL_RESET[REG_PHOTO];
      lv_c = KEY_LEVEL_RESET[REG_BRIGHTER];
      lv_e = KEY_LEVEL_RESET[REG_DIMMER];
      send_readings(12'd0, 12'd0, 12'd0);
      send_readings(12'hfff, 12'hfff, 12'hfff);
      // focus pulse only on the first sample of a run, window edges strict
      send_offsets(0, 21, lv_a);
      send_offsets(0, 20, lv_a);
      send_offsets(0, -21, lv_a + 12'd49);
      send_offsets(-21, 0, lv_a + 12'd50);
      send_offsets(21, 0, lv_a - 12'd49);
      send_offsets(20, 19, lv_b);
      send_offsets(-20, -19, lv_b - 12'd50);
      // brightness climbs to the clamp, then falls to zero
      send_offsets(21, 21, lv_c);
      send_offsets(-21, 21, lv_c);
      send_offsets(21, -21, lv_c);
      send_offsets(-21, -21, lv_c);
      send_offsets(19, -21, lv_c);
      send_offsets(50, 50, lv_e);
      send_offsets(-50, 50, lv_e);
      send_offsets(50, -50, lv_e);
      send_offsets(0, 0, lv_e);
      send_offsets(0, 0, lv_e);
      send_offsets(-19, 50, KEY_LEVEL_RESET[REG_TURN_POS]);
      send_offsets(50, -19, KEY_LEVEL_RESET[REG_TURN_NEG]);
      send_offsets(-50, 0, KEY_LEVEL_RESET[REG_BACK]);
      send_offsets(0, -50, KEY_LEVEL_RESET[REG_ARM_ONE]);
      send_offsets(-50, -50, 12'(ARM_TWO_LEVEL));
      send_offsets(50, 50, 12'hfff);
      req_valid <= 1'b0;
   endtask

   // Hold each ladder reading for a short run so pulses and steps repeat.
   task automatic run_random(int count);
      int hold_left;
      logic [11:0] ladder;
      hold_left = 0;
      ladder = '0;
      for (int n = 0; n < count; n++) begin
         if (hold_left == 0) begin
            ladder = pick_ladder();
            hold_left = $urandom_range(6, 1);
         end
         hold_left--;
         send_readings(pick_stick_raw(), pick_stick_raw(), ladder);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(level_style_e style);
      int base;
      level_type lvl;
      base = $urandom_range(4035);
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         case (style)
            CFG_DEFAULT: lvl = KEY_LEVEL_RESET[i];
            CFG_LOW:     lvl = 12'd0;
            CFG_HIGH:    lvl = 12'hfff;
            CFG_CLUSTER: begin
               lvl = 12'(base + int'($urandom_range(60)));
               // at times copy the level two registers down, e.g. dimmer from brighter, turn_neg from turn_pos
               if (i >= 2 && $urandom_range(3) == 0) lvl = model.key_level[i - 2];
            end
            default:     lvl = 12'($urandom_range(4095));
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= csr_reg_type'(i);
         csr_wdata <= lvl;
         model.key_level[i] = lvl;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_stick_x_raw = '0;
      req_stick_y_raw = '0;
      req_ladder_raw = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_FOCUS;
      csr_wdata = '0;
      model = new(ARM_TWO_LEVEL);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         configure(PHASE_STYLE[p]);
         send_idle_pct = PHASE_SEND_IDLE[p];
         recv_stall_pct = PHASE_RECV_STALL[p];
         // back up the pipe while the sender keeps offering
         if (p == 0) hold_off_pending = 1'b1;
         run_random(ITEMS_PER_PHASE);
      end
      drain();
      if (model.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
